### rtl/core/acsc_pkg.sv
// Shared types, constants and AES byte functions for the counter-mode cipher core.
package acsc_pkg;

  localparam int unsigned RK_ROW_W  = 4;   // round key row index (11 to 15 rows)
  localparam int unsigned RK_WORD_W = 6;   // expanded key word index (up to 60 words)

  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_0    = 3'd1;
  localparam logic [2:0] REG_KEY_1    = 3'd2;
  localparam logic [2:0] REG_KEY_2    = 3'd3;
  localparam logic [2:0] REG_KEY_3    = 3'd4;
  localparam logic [2:0] REG_IV_HI    = 3'd5;
  localparam logic [2:0] REG_IV_LO    = 3'd6;

  localparam logic [7:0]  RCON_FIRST = 8'h01;
  localparam logic [3:0]  ROUNDS_128 = 4'd10;
  localparam logic [3:0]  ROUNDS_256 = 4'd14;
  localparam logic [4:0]  BYTES_FULL = 5'd16;

  typedef struct packed {
    logic                en;
    logic [RK_ROW_W-1:0] row;
    logic [127:0]        data;
  } rk_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5, 8'h30, 8'h01, 8'h67, 8'h2B,
    8'hFE, 8'hD7, 8'hAB, 8'h76, 8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
    8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0, 8'hB7, 8'hFD, 8'h93, 8'h26,
    8'h36, 8'h3F, 8'hF7, 8'hCC, 8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
    8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A, 8'h07, 8'h12, 8'h80, 8'hE2,
    8'hEB, 8'h27, 8'hB2, 8'h75, 8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
    8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84, 8'h53, 8'hD1, 8'h00, 8'hED,
    8'h20, 8'hFC, 8'hB1, 8'h5B, 8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
    8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85, 8'h45, 8'hF9, 8'h02, 8'h7F,
    8'h50, 8'h3C, 8'h9F, 8'hA8, 8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
    8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2, 8'hCD, 8'h0C, 8'h13, 8'hEC,
    8'h5F, 8'h97, 8'h44, 8'h17, 8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88, 8'h46, 8'hEE, 8'hB8, 8'h14,
    8'hDE, 8'h5E, 8'h0B, 8'hDB, 8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
    8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79, 8'hE7, 8'hC8, 8'h37, 8'h6D,
    8'h8D, 8'hD5, 8'h4E, 8'hA9, 8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
    8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6, 8'hE8, 8'hDD, 8'h74, 8'h1F,
    8'h4B, 8'hBD, 8'h8B, 8'h8A, 8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
    8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E, 8'hE1, 8'hF8, 8'h98, 8'h11,
    8'h69, 8'hD9, 8'h8E, 8'h94, 8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
    8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2D, 8'h0F,
    8'hB0, 8'h54, 8'hBB, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // State byte i sits at [127-8i -: 8]; column c holds bytes 4c..4c+3.
  function automatic logic [127:0] sub_shift(input logic [127:0] st);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        r[127-8*(4*c+k) -: 8] = SBOX[st[127-8*(4*((c+k)%4)+k) -: 8]];
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] st);
    logic [127:0] r;
    logic [7:0]   a0, a1, a2, a3, al;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = st[127-32*c -: 8];
      a1 = st[119-32*c -: 8];
      a2 = st[111-32*c -: 8];
      a3 = st[103-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      r[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      r[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      r[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      r[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return r;
  endfunction

endpackage

### rtl/core/acsc_key_exp.sv
// Key schedule: one expanded key word per cycle, written out as 128-bit round key rows.
module acsc_key_exp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    wide_i,
  input  logic [255:0]            key_i,
  output acsc_pkg::rk_wr_t        rk_wr_o,
  output logic                    busy_o,
  output logic                    done_o
);
  import acsc_pkg::*;

  logic                 busy_q, busy_d;
  logic                 wide_q, wide_d;
  logic [RK_WORD_W-1:0] idx_q, idx_d;
  logic [7:0]           rcon_q, rcon_d;
  logic [31:0]          win_q [8];
  logic [31:0]          word, prev, back, t;
  logic                 from_key, last;

  always_comb begin
    prev     = win_q[7];
    back     = wide_q ? win_q[0] : win_q[4];
    from_key = (idx_q[RK_WORD_W-1:3] == '0) && (wide_q || !idx_q[2]);
    last     = idx_q == (wide_q ? RK_WORD_W'(59) : RK_WORD_W'(43));
    rcon_d   = rcon_q;
    t        = prev;
    if ((wide_q && idx_q[2:0] == 3'd0) || (!wide_q && idx_q[1:0] == 2'd0)) begin
      t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_q, 24'h0};
      if (busy_q && !from_key) rcon_d = xtime(rcon_q);
    end else if (wide_q && idx_q[2:0] == 3'd4) begin
      t = sub_word(prev);
    end
    word = from_key ? key_i[255-32*idx_q[2:0] -: 32] : (back ^ t);

    busy_d = busy_q;
    wide_d = wide_q;
    idx_d  = idx_q;
    if (start_i) begin
      busy_d = 1'b1;
      wide_d = wide_i;
      idx_d  = '0;
      rcon_d = RCON_FIRST;
    end else if (busy_q) begin
      idx_d = idx_q + RK_WORD_W'(1);
      if (last) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      wide_q <= 1'b0;
      idx_q  <= '0;
      rcon_q <= RCON_FIRST;
    end else begin
      busy_q <= busy_d;
      wide_q <= wide_d;
      idx_q  <= idx_d;
      rcon_q <= rcon_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      for (int k = 0; k < 7; k++) win_q[k] <= win_q[k+1];
      win_q[7] <= word;
    end
  end

  assign rk_wr_o.en   = busy_q && (idx_q[1:0] == 2'd3);
  assign rk_wr_o.row  = idx_q[RK_WORD_W-1:2];
  assign rk_wr_o.data = {win_q[5], win_q[6], win_q[7], word};
  assign busy_o       = busy_q;
  assign done_o       = busy_q && last;

endmodule

### rtl/core/aes_ctr_stream_cipher_core.sv
// AES-128/256 counter-mode cipher core: stream ports, config registers, round sequencer.
// A chunk is taken in the idle state; the pre state loads the counter and fetches the first
// round key, the round state runs the initial key addition and then each of the 10 or 14 AES
// rounds, and the done state posts the result once the previous one has been taken, all through
// a single shared round unit that reads one 128-bit round key row per cycle from a small key
// memory. A chunk with the restart flag first runs the key schedule, one word per cycle,
// expanding 44 words for AES-128 and 60 for AES-256. A byte count of zero returns a zero result
// without touching the counter; counts above sixteen are treated as sixteen. The result waits
// in an output register and the next chunk is accepted while it is held.
module aes_ctr_stream_cipher_core #(
  parameter int unsigned MAX_ROUNDS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,   // data_hi, data_lo, byte_count, zero pad
  input  logic         s_axis_tuser,   // restart
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // out_hi, out_lo, out_count, zero pad
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [63:0]  cfg_wdata_i
);
  import acsc_pkg::*;

  localparam int unsigned RkRows = MAX_ROUNDS + 1;
  localparam int unsigned RndW   = $clog2(RkRows);
  localparam bit          HasWide = MAX_ROUNDS >= 14;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_KEY   = 3'd1;
  localparam logic [2:0] ST_PRE   = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic            key_size_q;
  logic [63:0]     key0_q, key1_q, key2_q, key3_q, ivhi_q, ivlo_q;
  logic [127:0]    ctr_q;
  logic            wide_q;
  logic [127:0]    din_q, st_q, rk_q, round_out;
  logic [4:0]      cnt_q;
  logic [RndW-1:0] rnd_q, nr;
  logic [127:0]    rk_mem [RkRows];
  logic            out_vld_q;
  logic [127:0]    out_q, res;
  logic [4:0]      out_cnt_q;
  logic            accept, kx_start, kx_busy, kx_done, wide_sel;
  rk_wr_t          kx_wr;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign wide_sel = key_size_q && HasWide;
  assign kx_start = accept && s_axis_tuser;
  assign nr       = wide_q ? RndW'(ROUNDS_256) : RndW'(ROUNDS_128);

  acsc_key_exp u_key_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (kx_start),
    .wide_i  (wide_sel),
    .key_i   ({key0_q, key1_q, key2_q, key3_q}),
    .rk_wr_o (kx_wr),
    .busy_o  (kx_busy),
    .done_o  (kx_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q <= 1'b0;
      key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0;
      ivhi_q <= '0; ivlo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_KEY_SIZE: key_size_q <= cfg_wdata_i[0];
        REG_KEY_0:    key0_q     <= cfg_wdata_i;
        REG_KEY_1:    key1_q     <= cfg_wdata_i;
        REG_KEY_2:    key2_q     <= cfg_wdata_i;
        REG_KEY_3:    key3_q     <= cfg_wdata_i;
        REG_IV_HI:    ivhi_q     <= cfg_wdata_i;
        REG_IV_LO:    ivlo_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Round key memory: one write port from the schedule, one registered read port.
  always_ff @(posedge clk_i) begin
    if (kx_wr.en) rk_mem[kx_wr.row[RndW-1:0]] <= kx_wr.data;
    if (state_d == ST_ROUND) rk_q <= rk_mem[(state_q == ST_PRE) ? '0 : rnd_q + RndW'(1)];
  end

  // Shared round unit: round 0 is the initial key addition, last round skips MixColumns.
  always_comb begin
    if (rnd_q == '0) round_out = st_q ^ rk_q;
    else if (rnd_q == nr) round_out = sub_shift(st_q) ^ rk_q;
    else round_out = mix_columns(sub_shift(st_q)) ^ rk_q;
  end

  always_comb begin
    for (int b = 0; b < 16; b++) begin
      res[127-8*b -: 8] = (5'(b) < cnt_q) ? (din_q[127-8*b -: 8] ^ st_q[127-8*b -: 8]) : 8'h00;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = s_axis_tuser ? ST_KEY :
                                     (s_axis_tdata[132:128] == '0) ? ST_DONE : ST_PRE;
      ST_KEY:   if (kx_done) state_d = (cnt_q == '0) ? ST_DONE : ST_PRE;
      ST_PRE:   state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == nr) state_d = ST_DONE;
      ST_DONE:  if (!out_vld_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ctr_q     <= '0;
      wide_q    <= 1'b0;
      rnd_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (kx_start) begin
        ctr_q  <= {ivhi_q, ivlo_q};
        wide_q <= wide_sel;
      end
      if (state_q == ST_PRE) rnd_q <= '0;
      else if (state_q == ST_ROUND && rnd_q != nr) rnd_q <= rnd_q + RndW'(1);
      if (m_axis_tvalid && m_axis_tready) out_vld_q <= 1'b0;
      if (state_q == ST_DONE && state_d == ST_IDLE) begin
        out_vld_q <= 1'b1;
        if (cnt_q != '0) ctr_q <= ctr_q + 128'd1;
      end
    end
  end

  // din_q holds {data_hi, data_lo}, byte 0 at the top
  always_ff @(posedge clk_i) begin
    if (accept) begin
      din_q <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
      cnt_q <= (s_axis_tdata[132:128] > BYTES_FULL) ? BYTES_FULL : s_axis_tdata[132:128];
    end
    if (state_q == ST_PRE) st_q <= ctr_q;
    else if (state_q == ST_ROUND) st_q <= round_out;
    if (state_q == ST_DONE && state_d == ST_IDLE) begin
      out_q     <= res;
      out_cnt_q <= cnt_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_cnt_q, out_q[63:0], out_q[127:64]};

  a_kx_only_in_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kx_busy |-> state_q == ST_KEY) else $error("key schedule running outside key state");
  a_rnd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |-> rnd_q <= nr) else $error("round counter overrun");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready) else $error("second chunk taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending result changed");

endmodule
